// ===== design/sma_pkg.sv =====
`timescale 1ns / 1ps

package sma_pkg;

    localparam int WORD_W          = 32;
    localparam int STEP_W          = 5;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_SWAP = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [WORD_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] top_word;
        logic [DEPTH_OUT_W-1:0]   depth_now;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } unit_rsp_t;

endpackage

// ===== design/sma_ram.sv =====
`timescale 1ns / 1ps

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sma_unit.sv =====
`timescale 1ns / 1ps

module sma_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  sma_pkg::unit_req_t req,
    output sma_pkg::unit_rsp_t rsp
);

    import sma_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_RUN  = 3'b010,
        U_FIX  = 3'b100
    } ustate_t;

    ustate_t           state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic              is_div;
    logic              sub;
    logic              last;
    logic [WORD_W-1:0] fix_src;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] a_mag;
    logic [WORD_W-1:0] b_mag;

    // one shared adder: add, sub, multiply accumulate, trial subtract, sign fix
    always_comb
    begin
        is_div  = (op_reg == OP_DIV) || (op_reg == OP_MOD);
        fix_src = (op_reg == OP_DIV) ? q_reg : acc_reg;
        if (state_reg == U_FIX)
        begin
            x = '0;
        end
        else if (is_div)
        begin
            x = {acc_reg[WORD_W-2:0], q_reg[WORD_W-1]};
        end
        else
        begin
            x = acc_reg;
        end
        y    = (state_reg == U_FIX) ? fix_src : b_reg;
        sub  = (state_reg == U_FIX) || (op_reg == OP_SUB) || is_div;
        sum  = {1'b0, x} + {1'b0, y ^ {WORD_W{sub}}} + {{WORD_W{1'b0}}, sub};
        last = (cnt_reg == {STEP_W{1'b1}});
        a_mag = req.a[WORD_W-1] ? (~req.a + {{(WORD_W-1){1'b0}}, 1'b1}) : req.a;
        b_mag = req.b[WORD_W-1] ? (~req.b + {{(WORD_W-1){1'b0}}, 1'b1}) : req.b;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        b_next      = b_reg;
        cnt_next    = cnt_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    neg_q_next = req.a[WORD_W-1] ^ req.b[WORD_W-1];
                    neg_r_next = req.a[WORD_W-1];
                    state_next = U_RUN;
                    if ((req.op == OP_ADD) || (req.op == OP_SUB))
                    begin
                        acc_next = req.a;
                        b_next   = req.b;
                        cnt_next = {STEP_W{1'b1}};
                    end
                    else if (req.op == OP_MUL)
                    begin
                        acc_next = '0;
                        q_next   = req.a;
                        b_next   = req.b;
                        cnt_next = '0;
                    end
                    else
                    begin
                        acc_next = '0;
                        q_next   = a_mag;
                        b_next   = b_mag;
                        cnt_next = '0;
                    end
                end
            end
            U_RUN:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        result_next = sum[WORD_W-1:0];
                        done_next   = 1'b1;
                        state_next  = U_IDLE;
                    end
                    OP_MUL:
                    begin
                        acc_next = q_reg[0] ? sum[WORD_W-1:0] : acc_reg;
                        q_next   = {1'b0, q_reg[WORD_W-1:1]};
                        b_next   = {b_reg[WORD_W-2:0], 1'b0};
                        cnt_next = cnt_reg + {{(STEP_W-1){1'b0}}, 1'b1};
                        if (last)
                        begin
                            result_next = acc_next;
                            done_next   = 1'b1;
                            state_next  = U_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sum[WORD_W])
                        begin
                            acc_next = sum[WORD_W-1:0];
                            q_next   = {q_reg[WORD_W-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = x;
                            q_next   = {q_reg[WORD_W-2:0], 1'b0};
                        end
                        cnt_next = cnt_reg + {{(STEP_W-1){1'b0}}, 1'b1};
                        if (last)
                        begin
                            state_next = U_FIX;
                        end
                    end
                endcase
            end
            U_FIX:
            begin
                if ((op_reg == OP_DIV) ? neg_q_reg : neg_r_reg)
                begin
                    result_next = sum[WORD_W-1:0];
                end
                else
                begin
                    result_next = fix_src;
                end
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// ===== design/stack_machine_alu.sv =====
`timescale 1ns / 1ps

// Stack machine ALU: a bounded stack of 32-bit signed words driven by one
// operation per request, one result per request giving status, new top word and
// depth. The top word lives in a register and the words below it in a RAM, so
// each request needs at most one RAM read and one RAM write. A request goes
// from idle to finish for push, unused codes and errors, via read for swap
// and zero-divisor checks, and via read and execute for the rest, where the
// shared adder runs one shift-add or one restoring-division step per cycle.
// A new request is accepted while the previous result still waits to be taken.
module stack_machine_alu #(
    parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  sma_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output sma_pkg::res_t res
);

    import sma_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_PUSH,
        C_POP,
        C_SWAP
    } commit_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] top_reg, top_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    commit_t           kind_reg, kind_next;
    logic [WORD_W-1:0] new_top_reg, new_top_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [CNT_W-1:0]  cnt_minus1;
    logic [CNT_W-1:0]  cnt_minus2;
    logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    unit_req_t         ureq;
    unit_rsp_t         ursp;

    sma_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(top_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sma_unit u_unit (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (ureq),
        .rsp  (ursp)
    );

    assign cnt_minus1 = count_reg - ONE_CNT;
    assign cnt_minus2 = count_reg - TWO_CNT;
    assign ram_raddr  = cnt_minus2[AW-1:0];
    assign out_free   = !out_valid_reg || !res_stall;
    assign depth_ext  = {{DEPTH_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        kind_next      = kind_reg;
        new_top_next   = new_top_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_minus1[AW-1:0];
        ureq.start     = 1'b0;
        ureq.op        = op_reg;
        ureq.a         = ram_rdata;
        ureq.b         = top_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd.operation;
                    status_next = ST_OK;
                    kind_next   = C_NONE;
                    state_next  = S_FIN;
                    if (cmd.operation == OP_PUSH)
                    begin
                        if (count_reg >= FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            kind_next    = C_PUSH;
                            new_top_next = cmd.push_value;
                        end
                    end
                    else if (cmd.operation <= OP_MOD)
                    begin
                        if (count_reg < TWO_CNT)
                        begin
                            status_next = ST_SHORT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_FIN;
                if (op_reg == OP_SWAP)
                begin
                    kind_next    = C_SWAP;
                    new_top_next = ram_rdata;
                end
                else if (((op_reg == OP_DIV) || (op_reg == OP_MOD)) && (top_reg == '0))
                begin
                    status_next = ST_DIV0;
                end
                else
                begin
                    ureq.start = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ursp.done)
                begin
                    kind_next    = C_POP;
                    new_top_next = ursp.result;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    case (kind_reg)
                        C_PUSH:
                        begin
                            ram_we     = (count_reg != '0);
                            count_next = count_reg + ONE_CNT;
                            top_next   = new_top_reg;
                        end
                        C_SWAP:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_minus2[AW-1:0];
                            top_next  = new_top_reg;
                        end
                        C_POP:
                        begin
                            count_next = cnt_minus1;
                            top_next   = new_top_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next     = 1'b1;
                    out_next.status    = status_reg;
                    out_next.top_word  = (count_next == '0) ? '0 : top_next;
                    out_next.depth_now = depth_ext[DEPTH_OUT_W-1:0];
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        op_reg      <= op_next;
        status_reg  <= status_next;
        kind_reg    <= kind_next;
        new_top_reg <= new_top_next;
        out_reg     <= out_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stack count above depth");

    a_unit_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ursp.done |-> (state_reg == S_EXEC))
        else $error("arithmetic unit finished outside execute state");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.depth_now == '0) && (FULL_CNT[DEPTH_OUT_W-1:0] != '0))
            |-> (res.top_word == '0))
        else $error("empty stack reports nonzero top");

    a_short_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free && (status_reg != ST_OK))
            |=> ($stable(count_reg) && (res.status == $past(status_reg))))
        else $error("error request changed the stack depth");

endmodule
